// ===== rtl/core/dds_tuning_word_sequencer_top_defines.svh =====
// Assertion macros for the checker file.
`ifndef DDS_TUNING_WORD_SEQUENCER_TOP_DEFINES_SVH
`define DDS_TUNING_WORD_SEQUENCER_TOP_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define DTWS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dtws assertion failed");

// Next-cycle implication, disabled in reset.
`define DTWS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dtws assertion failed");

`endif

// ===== rtl/core/dtws_pkg.sv =====
package dtws_pkg;

    localparam int unsigned CLK_W   = 26;
    localparam int unsigned FREQ_W  = 32;
    localparam int unsigned VALUE_W = 27;   // (freq + offset) >> 5
    localparam int unsigned TW_W    = 24;
    localparam int unsigned WORD_W  = 16;
    localparam int unsigned DIV_STEPS = VALUE_W + TW_W;
    localparam int unsigned CNT_W   = $clog2(DIV_STEPS);

    localparam logic [CLK_W-1:0] CLK_RESET = CLK_W'(50000000);

    localparam logic [1:0] SB_NONE  = 2'd0;
    localparam logic [1:0] SB_UPPER = 2'd1;
    localparam logic [1:0] SB_LOWER = 2'd2;

    localparam logic [FREQ_W-1:0] OFS_NONE  = 32'd21600000;
    localparam logic [FREQ_W-1:0] OFS_UPPER = 32'd21601500;
    localparam logic [FREQ_W-1:0] OFS_LOWER = 32'd21598500;

    localparam logic [2:0] W_CTRL     = 3'd0;
    localparam logic [2:0] W_START_LO = 3'd1;
    localparam logic [2:0] W_START_HI = 3'd2;
    localparam logic [2:0] W_INCR_LO  = 3'd3;
    localparam logic [2:0] W_INCR_HI  = 3'd4;
    localparam logic [2:0] W_COUNT    = 3'd5;

    typedef struct packed {
        logic               start;
        logic [VALUE_W-1:0] value;
        logic [CLK_W-1:0]   divisor;
    } div_ctrl_t;

    typedef struct packed {
        logic            done;
        logic [TW_W-1:0] quotient;
    } div_stat_t;

    function automatic logic [FREQ_W-1:0] offset_of(input logic [1:0] mode);
        logic [FREQ_W-1:0] ofs;
        unique case (mode)
            SB_UPPER: ofs = OFS_UPPER;
            SB_LOWER: ofs = OFS_LOWER;
            default:  ofs = OFS_NONE;
        endcase
        return ofs;
    endfunction

    function automatic logic [WORD_W-1:0] word_of(input logic [2:0] idx,
                                                 input logic [TW_W-1:0] tw);
        logic [WORD_W-1:0] w;
        unique case (idx)
            W_CTRL:     w = 16'h0FFF;
            W_START_LO: w = {4'hC, tw[11:0]};
            W_START_HI: w = {4'hD, tw[23:12]};
            W_INCR_LO:  w = 16'h2002;
            W_INCR_HI:  w = 16'h3000;
            W_COUNT:    w = 16'h1002;
            default:    w = '0;
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/core/dtws_div.sv =====
module dtws_div
(
    input  logic                clk,
    input  logic                rst_n,
    input  dtws_pkg::div_ctrl_t ctrl,
    output dtws_pkg::div_stat_t stat
);

    logic                        busy_reg, busy_next;
    logic [dtws_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic [dtws_pkg::VALUE_W-1:0] dvd_reg, dvd_next;
    logic [dtws_pkg::CLK_W-1:0]   dsr_reg, dsr_next;
    logic [dtws_pkg::CLK_W-1:0]   rem_reg, rem_next;
    logic [dtws_pkg::TW_W-1:0]    q_reg, q_next;
    logic                        done_reg, done_next;

    logic [dtws_pkg::CLK_W:0]     trial;
    logic                        fits;

    // restoring division, one quotient bit per cycle; value followed by 24 zeros
    assign trial = {rem_reg, dvd_reg[dtws_pkg::VALUE_W-1]};
    assign fits  = trial >= {1'b0, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        done_next = 1'b0;
        if (ctrl.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = ctrl.value;
            dsr_next  = ctrl.divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[dtws_pkg::VALUE_W-2:0], 1'b0};
            // zero divisor: every step fits, quotient saturates to all ones
            rem_next = fits ? dtws_pkg::CLK_W'(trial - {1'b0, dsr_reg})
                            : trial[dtws_pkg::CLK_W-1:0];
            q_next   = {q_reg[dtws_pkg::TW_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == dtws_pkg::CNT_W'(dtws_pkg::DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
    end

    assign stat.done     = done_reg;
    assign stat.quotient = q_reg;

endmodule

// ===== rtl/core/dds_tuning_word_sequencer_top.sv =====
// channel  | handshake               | payload
// dial     | dial_valid / dial_stall | dial_frequency[31:0], sideband_mode[1:0]
// word     | word_valid / word_stall | spi_word[15:0], last_word
// config   | cfg_write               | cfg_data[25:0] (master clock, Hz)
//
// A dial word whose DDS value matches the stored one is accepted and emits nothing.
// A new value starts the bit-serial divider (one quotient bit per cycle over a
// 27+24 bit dividend); the tuning word is then latched and the six words go out.
// After a new value is accepted, dial_stall is high until the last word is taken.
// word_stall holds the current word; reset restores a 50 MHz master clock.
module dds_tuning_word_sequencer_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        dial_valid,
    output logic        dial_stall,
    input  logic [31:0] dial_frequency,
    input  logic [1:0]  sideband_mode,
    output logic        word_valid,
    input  logic        word_stall,
    output logic [15:0] spi_word,
    output logic        last_word,
    input  logic        cfg_write,
    input  logic [25:0] cfg_data
);

    typedef enum logic [2:0]
    {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_EMIT = 3'b100
    } state_t;

    state_t                       state_reg, state_next;
    logic [dtws_pkg::CLK_W-1:0]   mclk_reg;
    logic [dtws_pkg::VALUE_W-1:0] last_reg, last_next;
    logic [dtws_pkg::TW_W-1:0]    tw_reg, tw_next;
    logic [2:0]                   idx_reg, idx_next;

    logic [dtws_pkg::FREQ_W-1:0]  sum;
    logic [dtws_pkg::VALUE_W-1:0] value;
    logic                         accept;
    dtws_pkg::div_ctrl_t          div_ctrl;
    dtws_pkg::div_stat_t          div_stat;

    assign sum    = dial_frequency + dtws_pkg::offset_of(sideband_mode);
    assign value  = sum[dtws_pkg::FREQ_W-1:5];
    assign accept = dial_valid && !dial_stall;

    assign dial_stall = (state_reg != S_IDLE);
    assign word_valid = (state_reg == S_EMIT);
    assign spi_word   = dtws_pkg::word_of(idx_reg, tw_reg);
    assign last_word  = (idx_reg == dtws_pkg::W_COUNT);

    assign div_ctrl.start   = accept && (value != last_reg);
    assign div_ctrl.value   = value;
    assign div_ctrl.divisor = mclk_reg;

    dtws_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (div_ctrl),
        .stat  (div_stat)
    );

    always_comb
    begin
        state_next = state_reg;
        last_next  = last_reg;
        tw_next    = tw_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (div_ctrl.start)
                begin
                    last_next  = value;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_stat.done)
                begin
                    tw_next    = div_stat.quotient;
                    idx_next   = dtws_pkg::W_CTRL;
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!word_stall)
                begin
                    if (idx_reg == dtws_pkg::W_COUNT)
                        state_next = S_IDLE;
                    else
                        idx_next = idx_reg + 3'd1;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            mclk_reg  <= dtws_pkg::CLK_RESET;
            last_reg  <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write)
                mclk_reg <= cfg_data;
            last_reg  <= last_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tw_reg <= tw_next;
    end

endmodule

// ===== rtl/core/dtws_chk.sv =====
`include "dds_tuning_word_sequencer_top_defines.svh"

module dtws_chk
(
    input logic        clk,
    input logic        rst_n,
    input logic        dial_valid,
    input logic        dial_stall,
    input logic        word_valid,
    input logic        word_stall,
    input logic [15:0] spi_word,
    input logic        last_word
);

    `DTWS_ASSERT_NEXT(a_word_hold, clk, rst_n, word_valid && word_stall, word_valid && $stable(spi_word) && $stable(last_word))

    // one dial word at a time: no intake while words go out
    `DTWS_ASSERT_NOW(a_busy_stall, clk, rst_n, word_valid, dial_stall)

    // the divider runs before any word shows
    `DTWS_ASSERT_NEXT(a_no_early_word, clk, rst_n, dial_valid && !dial_stall, !word_valid)

    // burst words follow back to back
    `DTWS_ASSERT_NEXT(a_burst_cont, clk, rst_n, word_valid && !word_stall && !last_word, word_valid)

    `DTWS_ASSERT_NEXT(a_burst_end, clk, rst_n, word_valid && !word_stall && last_word, !word_valid)

endmodule

bind dds_tuning_word_sequencer_top dtws_chk u_dtws_chk
(
    .clk        (clk),
    .rst_n      (rst_n),
    .dial_valid (dial_valid),
    .dial_stall (dial_stall),
    .word_valid (word_valid),
    .word_stall (word_stall),
    .spi_word   (spi_word),
    .last_word  (last_word)
);
